### design/sawarq_pkg.sv
// ----------------------------------------------------------------------------
// sawarq_pkg
// shared types and constants for the stop-and-wait arq link controller
// ----------------------------------------------------------------------------
package sawarq_pkg;

    typedef enum logic [2:0] {
        MODE_START      = 3'd0,
        MODE_HOST_SEND  = 3'd1,
        MODE_COMMIT     = 3'd2,
        MODE_RELEASE    = 3'd3,
        MODE_RADIO_DONE = 3'd4,
        MODE_TX_UNDER   = 3'd5,
        MODE_RX_OVER    = 3'd6,
        MODE_RX_TIMEOUT = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        CMD_NONE        = 3'd0,
        CMD_TX          = 3'd1,
        CMD_LISTEN_RESP = 3'd2,
        CMD_ACK         = 3'd3,
        CMD_NAK         = 3'd4,
        CMD_LISTEN_DATA = 3'd5
    } t_cmd;

    localparam logic [1:0] CFG_IS_TRANSMITTER = 2'd0;
    localparam logic [1:0] CFG_DATA_TIMEOUT   = 2'd1;
    localparam logic [1:0] CFG_RESP_TIMEOUT   = 2'd2;

    localparam logic [7:0] ACK_CODE           = 8'd255;
    localparam logic [7:0] SLAVE_START_ID     = 8'd255;
    localparam logic [7:0] DATA_TIMEOUT_RESET = 8'd50;
    localparam logic [7:0] RESP_TIMEOUT_RESET = 8'd2;

    typedef struct packed {
        t_mode      mode;
        logic       crc_ok;
        logic [7:0] response_byte;
        logic [7:0] rx_packet_id;
    } t_in_item;

    typedef struct packed {
        t_cmd       command;
        logic [2:0] slot;
        logic [7:0] packet_id;
        logic       append_id;
        logic [7:0] timeout_ms;
        logic       recalibrate;
        logic       strip_id;
        logic       complete;
        logic       tx_ready;
        logic [2:0] host_slot;
        logic       host_slot_valid;
        logic [3:0] backlog;
    } t_out_item;

    typedef struct packed {
        logic       is_transmitter;
        logic [7:0] data_listen_timeout_ms;
        logic [7:0] response_timeout_ms;
    } t_cfg;

endpackage

### design/sawarq_core.sv
// ----------------------------------------------------------------------------
// sawarq_core
// link state registers and the per-word event decode
// ----------------------------------------------------------------------------
module sawarq_core #(
    parameter int BUFFER_SLOTS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  sawarq_pkg::t_in_item  i_item,
    input  sawarq_pkg::t_cfg      i_cfg,
    output sawarq_pkg::t_out_item o_result
);
    import sawarq_pkg::*;

    localparam int IDX_W = (BUFFER_SLOTS > 2) ? $clog2(BUFFER_SLOTS) : 1;
    localparam int CNT_W = $clog2(BUFFER_SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUFFER_SLOTS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(BUFFER_SLOTS);

    logic [IDX_W-1:0] r_host_index, n_host_index;
    logic [IDX_W-1:0] r_radio_index, n_radio_index;
    logic [CNT_W-1:0] r_free_count, n_free_count;
    logic [7:0]       r_current_id, n_current_id;
    logic             r_busy, n_busy;
    logic             r_awaiting, n_awaiting;
    logic             r_resending, n_resending;
    logic             r_replying, n_replying;
    logic             r_replied_ack, n_replied_ack;

    t_cmd             cmd;
    logic [7:0]       pid;
    logic [7:0]       tmo;
    logic             append, recal, strip, done, resend, relisten, master;
    logic [CNT_W-1:0] backlog;
    logic [IDX_W+2:0] radio_ext, host_ext;
    logic [CNT_W+3:0] backlog_ext;

    function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx);
        next_index = (idx >= LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    assign master = i_cfg.is_transmitter;

    always_comb begin
        n_host_index  = r_host_index;
        n_radio_index = r_radio_index;
        n_free_count  = r_free_count;
        n_current_id  = r_current_id;
        n_busy        = r_busy;
        n_awaiting    = r_awaiting;
        n_resending   = r_resending;
        n_replying    = r_replying;
        n_replied_ack = r_replied_ack;
        cmd      = CMD_NONE;
        pid      = '0;
        tmo      = '0;
        append   = 1'b0;
        recal    = 1'b0;
        strip    = 1'b0;
        done     = 1'b0;
        resend   = 1'b0;
        relisten = 1'b0;

        case (i_item.mode)
            MODE_START: begin
                n_host_index  = '0;
                n_radio_index = '0;
                n_free_count  = FULL_CNT;
                n_current_id  = master ? 8'd0 : SLAVE_START_ID;
                n_busy        = 1'b0;
                n_awaiting    = 1'b0;
                n_resending   = 1'b0;
                n_replying    = 1'b0;
                n_replied_ack = 1'b0;
                relisten      = !master;
            end
            MODE_HOST_SEND: begin
                if (master && !r_busy) begin
                    n_busy = 1'b1;
                    cmd    = CMD_TX;
                    pid    = r_current_id;
                    append = !r_resending;
                end
            end
            MODE_COMMIT: begin
                if (master && r_free_count != '0) begin
                    n_host_index = next_index(r_host_index);
                    n_free_count = r_free_count - 1'b1;
                end
            end
            MODE_RELEASE: begin
                if (!master && r_free_count < FULL_CNT) begin
                    n_host_index = next_index(r_host_index);
                    n_free_count = r_free_count + 1'b1;
                end
            end
            MODE_RADIO_DONE: begin
                if (master) begin
                    if (!r_awaiting) begin
                        n_awaiting = 1'b1;
                        cmd        = CMD_LISTEN_RESP;
                        tmo        = i_cfg.response_timeout_ms;
                    end else begin
                        n_awaiting = 1'b0;
                        if (i_item.response_byte == ACK_CODE) begin
                            n_radio_index = next_index(r_radio_index);
                            n_current_id  = r_current_id + 8'd1;
                            if (r_free_count < FULL_CNT) begin
                                n_free_count = r_free_count + 1'b1;
                            end
                            done        = 1'b1;
                            n_resending = 1'b0;
                            n_busy      = 1'b0;
                        end else begin
                            resend = 1'b1;
                        end
                    end
                end else begin
                    if (!r_replying) begin
                        n_replying    = 1'b1;
                        n_replied_ack = i_item.crc_ok;
                        cmd           = i_item.crc_ok ? CMD_ACK : CMD_NAK;
                    end else begin
                        n_replying = 1'b0;
                        if (r_replied_ack) begin
                            n_replied_ack = 1'b0;
                            if (i_item.rx_packet_id != r_current_id &&
                                r_free_count != '0) begin
                                n_current_id  = i_item.rx_packet_id;
                                strip         = 1'b1;
                                n_radio_index = next_index(r_radio_index);
                                n_free_count  = r_free_count - 1'b1;
                                done          = 1'b1;
                            end
                        end
                        relisten = 1'b1;
                    end
                end
            end
            default: begin
                recal = (i_item.mode != MODE_RX_TIMEOUT);
                if (master) begin
                    resend = 1'b1;
                end else begin
                    n_replying    = 1'b0;
                    n_replied_ack = 1'b0;
                    relisten      = 1'b1;
                end
            end
        endcase

        if (resend) begin
            n_awaiting  = 1'b0;
            n_resending = 1'b1;
            n_busy      = 1'b1;
            cmd         = CMD_TX;
            pid         = r_current_id;
            append      = 1'b0;
        end
        if (relisten) begin
            cmd = CMD_LISTEN_DATA;
            tmo = i_cfg.data_listen_timeout_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_host_index  <= '0;
            r_radio_index <= '0;
            r_free_count  <= FULL_CNT;
            r_current_id  <= '0;
            r_busy        <= 1'b0;
            r_awaiting    <= 1'b0;
            r_resending   <= 1'b0;
            r_replying    <= 1'b0;
            r_replied_ack <= 1'b0;
        end else if (i_accept) begin
            r_host_index  <= n_host_index;
            r_radio_index <= n_radio_index;
            r_free_count  <= n_free_count;
            r_current_id  <= n_current_id;
            r_busy        <= n_busy;
            r_awaiting    <= n_awaiting;
            r_resending   <= n_resending;
            r_replying    <= n_replying;
            r_replied_ack <= n_replied_ack;
        end
    end

    assign backlog     = FULL_CNT - n_free_count;
    assign radio_ext   = {3'b000, n_radio_index};
    assign host_ext    = {3'b000, n_host_index};
    assign backlog_ext = {4'b0000, backlog};

    always_comb begin
        o_result.command         = cmd;
        o_result.slot            = radio_ext[2:0];
        o_result.packet_id       = pid;
        o_result.append_id       = append;
        o_result.timeout_ms      = tmo;
        o_result.recalibrate     = recal;
        o_result.strip_id        = strip;
        o_result.complete        = done;
        o_result.tx_ready        = master && !n_busy;
        o_result.host_slot       = host_ext[2:0];
        o_result.host_slot_valid = master ? (n_free_count != '0) : (backlog != '0);
        o_result.backlog         = backlog_ext[3:0];
    end

endmodule

### design/sawarq_out_reg.sv
// ----------------------------------------------------------------------------
// sawarq_out_reg
// result register with valid/ready; refills in the cycle it is emptied
// ----------------------------------------------------------------------------
module sawarq_out_reg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  sawarq_pkg::t_out_item i_result,
    input  logic                  i_out_ready,
    output logic                  o_can_load,
    output logic                  o_out_valid,
    output sawarq_pkg::t_out_item o_out_data
);
    import sawarq_pkg::*;

    logic      r_valid;
    t_out_item r_data;

    assign o_can_load = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_data <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

### design/stop_and_wait_arq_link_controller.sv
// ----------------------------------------------------------------------------
// stop_and_wait_arq_link_controller
// stop-and-wait ack/nak link controller, master sender or slave receiver
// ----------------------------------------------------------------------------
// usage
//   input channel  : one event word per handshake (mode, crc, response, id)
//   output channel : one result word per event: radio command, slot, id,
//                    listen window and host status
//   config channel : index 0 role, 1 data listen window, 2 response window;
//                    always ready, write only while no event is in flight
// timing
//   result     : registered, valid in the cycle after the event is taken
//   throughput : one event per cycle while result words are taken; the link state updates
//                in the same cycle the event is taken, one result register follows
// reset
//   ring indices cleared, all slots free, id zero, flags cleared;
//   role slave, data window 50 ms, response window 2 ms
// stall
//   while the result register is held by the receiver, o_in_ready drops;
//   it rises again in the cycle the held word is taken
// ----------------------------------------------------------------------------
module stop_and_wait_arq_link_controller #(
    parameter int BUFFER_SLOTS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  sawarq_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output sawarq_pkg::t_out_item o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [7:0]            i_cfg_data
);
    import sawarq_pkg::*;

    t_cfg      r_cfg;
    t_out_item result;
    logic      accept;
    logic      can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.is_transmitter         <= 1'b0;
            r_cfg.data_listen_timeout_ms <= DATA_TIMEOUT_RESET;
            r_cfg.response_timeout_ms    <= RESP_TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IS_TRANSMITTER: r_cfg.is_transmitter         <= i_cfg_data[0];
                CFG_DATA_TIMEOUT:   r_cfg.data_listen_timeout_ms <= i_cfg_data;
                CFG_RESP_TIMEOUT:   r_cfg.response_timeout_ms    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = can_load;
    assign accept      = i_in_valid && can_load;

    sawarq_core #(
        .BUFFER_SLOTS(BUFFER_SLOTS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_data),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    sawarq_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (i_in_valid),
        .i_result    (result),
        .i_out_ready (i_out_ready),
        .o_can_load  (can_load),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    a_accept_gives_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid
    ) else $error("accepted event produced no result word");

    a_append_only_on_tx: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.append_id) |-> (o_out_data.command == CMD_TX)
    ) else $error("append id without transmit command");

    a_strip_means_complete: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.strip_id) |->
            (o_out_data.complete && o_out_data.command == CMD_LISTEN_DATA)
    ) else $error("strip id without delivery and relisten");

endmodule
